FILE: design/bffa_pkg.sv
// bffa_pkg: item types, codes and controller/datapath handshake structs
// for the bitmap first-fit allocator; no dependencies
`default_nettype none

package bffa_pkg;

  localparam int SIZE_W      = 16;
  localparam int ALOG_W      = 5;
  localparam int FCHUNK_W    = 8;
  localparam int STATUS_W    = 2;
  localparam int START_W     = 8;
  localparam int COUNT_W     = 9;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_INDEX_W = 1;

  // arithmetic width for chunk positions, run ends and counts
  localparam int WIDE_W = 17;

  // bitmap word: four chunks per memory word, one word per scan cycle
  localparam int LANES  = 4;
  localparam int LANE_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
  localparam logic [CFG_DATA_W-1:0] CHUNKS_IN_USE_RESET = 9'd256;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FIT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD    = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_CHUNK    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHUNKS_IN_USE = 1'd1;

  typedef struct packed {
    logic                opcode;
    logic [SIZE_W-1:0]   size_bytes;
    logic [ALOG_W-1:0]   align_log2;
    logic [FCHUNK_W-1:0] free_chunk;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  run_start;
    logic [COUNT_W-1:0]  free_chunks;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic scan_init;
    logic scan_run;
    logic mark_init;
    logic mark_run;
    logic fin_bad;
    logic fin_nofit;
    logic fin_ok;
    logic load_out;
    logic clr_run;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bad;
    logic is_free;
    logic scan_done;
    logic scan_found;
    logic mark_done;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/bffa_ctrl.sv
// bffa_ctrl: sequencer for clearing pass, scan, mark and result hand-off
// uses bffa_pkg for the command and status structs
`default_nettype none

module bffa_ctrl import bffa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MINIT,
    S_MARK,
    S_OUTPUT
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_run = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.bad) begin
          cmd.fin_bad = 1'b1;
          state_next  = S_OUTPUT;
        end else if (sts.is_free) begin
          state_next = S_MINIT;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          if (sts.scan_found) begin
            state_next = S_MINIT;
          end else begin
            cmd.fin_nofit = 1'b1;
            state_next    = S_OUTPUT;
          end
        end
      end
      S_MINIT: begin
        cmd.mark_init = 1'b1;
        state_next    = S_MARK;
      end
      S_MARK: begin
        cmd.mark_run = 1'b1;
        if (sts.mark_done) begin
          cmd.fin_ok = 1'b1;
          state_next = S_OUTPUT;
        end
      end
      S_OUTPUT: begin
        // result register frees up as the previous item leaves
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result loaded over an item not yet taken");

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CHECK))
    else $error("accepted item not decoded");

  a_valid_from_output: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(state == S_OUTPUT))
    else $error("result raised outside output state");

endmodule

`default_nettype wire

FILE: design/bffa_datapath.sv
// bffa_datapath: used bitmap memory, scan and mark engines, counters and
// configuration registers; uses bffa_pkg types and constants
`default_nettype none

module bffa_datapath import bffa_pkg::*; #(
  parameter int NUM_CHUNKS       = 256,
  parameter int CHUNK_BYTES_LOG2 = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  req_t                   in_item,
  output rsp_t                   out_item,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W     = $clog2(NUM_CHUNKS);
  localparam int WA_W      = IDX_W - LANE_W;
  localparam int NUM_WORDS = (NUM_CHUNKS + LANES - 1) / LANES;
  localparam int TOT_W     = $clog2(NUM_CHUNKS + 1);
  localparam int N_W       = SIZE_W + 1 - CHUNK_BYTES_LOG2;
  localparam logic [SIZE_W:0] ROUND_ADD = (SIZE_W + 1)'((1 << CHUNK_BYTES_LOG2) - 1);

  // configuration
  logic [CFG_DATA_W-1:0] base_chunk;
  logic [CFG_DATA_W-1:0] chunks_in_use;

  // request and bookkeeping
  req_t               req;
  logic [COUNT_W-1:0] used_count;

  // bitmap memory
  logic [LANES-1:0] mem [NUM_WORDS];
  logic [LANES-1:0] rdata;
  logic [LANES-1:0] wdata;
  logic [WA_W-1:0]  waddr;
  logic             we;

  // scan / mark pipeline
  logic [WA_W-1:0]  fetch_w;
  logic [WA_W-1:0]  pw;
  logic             pvalid;
  logic             cand_v;
  logic [IDX_W-1:0] cand;
  logic [N_W-1:0]   len;
  logic [IDX_W-1:0] run_lo;
  logic [IDX_W-1:0] lo;
  logic [IDX_W-1:0] hi;
  logic             mval;
  logic [WA_W-1:0]  clr_w;

  logic [STATUS_W-1:0] res_status;
  logic [START_W-1:0]  res_start;

  // decode
  logic [SIZE_W:0]    size_sum;
  logic [N_W-1:0]     n;
  logic [WIDE_W-1:0]  n_w;
  logic [TOT_W-1:0]   total;
  logic [WIDE_W-1:0]  total_w;
  logic [WIDE_W-1:0]  fchunk_w;
  logic [WIDE_W-1:0]  base_w;
  logic [ALOG_W-1:0]  sh;
  logic [WIDE_W-1:0]  mask;
  logic               is_free;
  logic               bad;
  logic [IDX_W-1:0]   lo_src;
  logic [WIDE_W-1:0]  hi_src_w;
  logic [WIDE_W-1:0]  lo_w;
  logic [WIDE_W-1:0]  cnt_add;
  logic [COUNT_W-1:0] count_after;
  logic [WIDE_W-1:0]  rem_w;

  // lane results
  logic               cv_n;
  logic [IDX_W-1:0]   cs_n;
  logic [N_W-1:0]     ln_n;
  logic               fnd;
  logic [IDX_W-1:0]   fstart;
  logic               last_word;
  logic [LANES-1:0]   mark_word;

  assign size_sum = {1'b0, req.size_bytes} + ROUND_ADD;
  assign n        = size_sum[SIZE_W:CHUNK_BYTES_LOG2];
  assign n_w      = WIDE_W'(n);
  assign total    = (WIDE_W'(chunks_in_use) > WIDE_W'(NUM_CHUNKS)) ?
                    TOT_W'(NUM_CHUNKS) : TOT_W'(chunks_in_use);
  assign total_w  = WIDE_W'(total);
  assign fchunk_w = WIDE_W'(req.free_chunk);
  assign base_w   = WIDE_W'(base_chunk);
  assign is_free  = (req.opcode == OP_FREE);
  assign bad      = (n == '0) ||
                    (is_free && ((fchunk_w >= total_w) || (fchunk_w + n_w > total_w)));

  // alignment in chunks as a low-bit mask on (start + base)
  assign sh   = (req.align_log2 > ALOG_W'(CHUNK_BYTES_LOG2)) ?
                (req.align_log2 - ALOG_W'(CHUNK_BYTES_LOG2)) : '0;
  assign mask = (sh >= ALOG_W'(WIDE_W)) ? '1 : ((WIDE_W'(1) << sh) - WIDE_W'(1));

  assign lo_src   = is_free ? fchunk_w[IDX_W-1:0] : run_lo;
  assign hi_src_w = WIDE_W'(lo_src) + n_w - WIDE_W'(1);
  assign lo_w     = WIDE_W'(lo);

  assign cnt_add = WIDE_W'(used_count) + n_w;
  always_comb begin
    if (is_free) begin
      count_after = (WIDE_W'(used_count) >= n_w) ? COUNT_W'(WIDE_W'(used_count) - n_w) : '0;
    end else begin
      count_after = (cnt_add > WIDE_W'(COUNT_MAX)) ? COUNT_MAX : cnt_add[COUNT_W-1:0];
    end
  end

  assign rem_w = (WIDE_W'(used_count) >= total_w) ? '0 : (total_w - WIDE_W'(used_count));

  // scan: four chunks a cycle, tracking the lowest aligned start in the free stretch
  always_comb begin
    logic [IDX_W-1:0] c;
    cv_n   = cand_v;
    cs_n   = cand;
    ln_n   = len;
    fnd    = 1'b0;
    fstart = cand;
    for (int k = 0; k < LANES; k++) begin
      c = {pw, LANE_W'(k)};
      if (!fnd && (WIDE_W'(c) < total_w)) begin
        if (rdata[k]) begin
          cv_n = 1'b0;
        end else if (cv_n) begin
          ln_n = ln_n + N_W'(1);
        end else if (((WIDE_W'(c) + base_w) & mask) == '0) begin
          cv_n = 1'b1;
          cs_n = c;
          ln_n = N_W'(1);
        end
        if (cv_n && (ln_n == n)) begin
          fnd    = 1'b1;
          fstart = cs_n;
        end
      end
    end
  end

  assign last_word = (WIDE_W'({pw, {LANE_W{1'b0}}}) + WIDE_W'(LANES)) >= total_w;

  // mark: set or clear the chunks of the run that fall in this word
  always_comb begin
    logic [IDX_W-1:0] c;
    for (int k = 0; k < LANES; k++) begin
      c = {pw, LANE_W'(k)};
      mark_word[k] = ((c >= lo) && (c <= hi)) ? mval : rdata[k];
    end
  end

  assign we    = cmd.clr_run || (cmd.mark_run && pvalid);
  assign waddr = cmd.clr_run ? clr_w : pw;
  assign wdata = cmd.clr_run ? '0 : mark_word;

  always_comb begin
    sts            = '0;
    sts.clr_last   = (clr_w == WA_W'(NUM_WORDS - 1));
    sts.bad        = bad;
    sts.is_free    = is_free;
    sts.scan_done  = pvalid && (fnd || last_word);
    sts.scan_found = pvalid && fnd;
    sts.mark_done  = pvalid && (pw == hi[IDX_W-1:LANE_W]);
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[fetch_w];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_chunk    <= '0;
      chunks_in_use <= CHUNKS_IN_USE_RESET;
      used_count    <= '0;
      clr_w         <= '0;
      fetch_w       <= '0;
      pvalid        <= 1'b0;
      cand_v        <= 1'b0;
      len           <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_BASE_CHUNK:    base_chunk    <= cfg_data;
          CFG_CHUNKS_IN_USE: chunks_in_use <= cfg_data;
        endcase
      end
      if (cmd.clr_run) clr_w <= clr_w + WA_W'(1);
      if (cmd.scan_init) begin
        fetch_w <= '0;
        pvalid  <= 1'b0;
        cand_v  <= 1'b0;
        len     <= '0;
      end
      if (cmd.mark_init) begin
        fetch_w <= lo_src[IDX_W-1:LANE_W];
        pvalid  <= 1'b0;
      end
      if (cmd.scan_run || cmd.mark_run) begin
        fetch_w <= fetch_w + WA_W'(1);
        pvalid  <= 1'b1;
      end
      if (cmd.scan_run && pvalid) begin
        cand_v <= cv_n;
        len    <= ln_n;
      end
      if (cmd.fin_ok) used_count <= count_after;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req <= in_item;
    if (cmd.scan_run || cmd.mark_run) pw <= fetch_w;
    if (cmd.scan_run && pvalid) cand <= cs_n;
    if (cmd.scan_run && pvalid && fnd) run_lo <= fstart;
    if (cmd.mark_init) begin
      lo   <= lo_src;
      hi   <= hi_src_w[IDX_W-1:0];
      mval <= !is_free;
    end
    if (cmd.fin_bad) begin
      res_status <= STATUS_BAD;
      res_start  <= '0;
    end
    if (cmd.fin_nofit) begin
      res_status <= STATUS_NO_FIT;
      res_start  <= '0;
    end
    if (cmd.fin_ok) begin
      res_status <= STATUS_DONE;
      res_start  <= is_free ? '0 : lo_w[START_W-1:0];
    end
    if (cmd.load_out) begin
      out_item.status      <= res_status;
      out_item.run_start   <= res_start;
      out_item.free_chunks <= rem_w[COUNT_W-1:0];
    end
  end

  a_mark_in_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.mark_run && pvalid) |->
      ((pw >= lo[IDX_W-1:LANE_W]) && (pw <= hi[IDX_W-1:LANE_W])))
    else $error("mark wrote a word outside the run");

  a_found_fits: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_run && sts.scan_found) |->
      ((((WIDE_W'(fstart) + base_w) & mask) == '0) && (WIDE_W'(fstart) + n_w <= total_w)))
    else $error("found run misaligned or past the region");

  a_alloc_count_up: assert property (@(posedge clk) disable iff (rst)
    (cmd.fin_ok && !is_free) |=> (used_count >= $past(used_count)))
    else $error("used count dropped on allocate");

endmodule

`default_nettype wire

FILE: design/bitmap_first_fit_allocator.sv
// bitmap_first_fit_allocator: top level joining sequencer and datapath
// uses bffa_pkg, bffa_ctrl and bffa_datapath
`default_nettype none

// Chunk allocator over NUM_CHUNKS chunks of 2**CHUNK_BYTES_LOG2 bytes, one used
// bit per chunk, held four chunks to a memory word. One item is worked at a
// time, but a new item is taken while the previous result waits in the output
// register. After reset a clearing pass zeroes the bitmap word by word before
// the first item is taken (configuration writes go through). A bad request
// goes from decode straight to the output register. An allocate scans one
// bitmap word per cycle from chunk 0 until the lowest aligned free run is
// found, then sets the run one word per cycle; a miss ends when the scan
// reaches the end of the region. A free skips the scan and clears the words
// the run touches. The bitmap is updated by read-modify-write of whole words.
module bitmap_first_fit_allocator import bffa_pkg::*; #(
  parameter int NUM_CHUNKS       = 256,
  parameter int CHUNK_BYTES_LOG2 = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  req_t                   in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rsp_t                   out_item,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;

  bffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bffa_datapath #(
    .NUM_CHUNKS       (NUM_CHUNKS),
    .CHUNK_BYTES_LOG2 (CHUNK_BYTES_LOG2)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire
